/* hw/rtl/rfd_pkg.sv */
// Shared types and constants for the run-length frame decoder.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package rfd_pkg;

    localparam int DISPLAY_BYTES_DEFAULT = 512;

    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 14;
    localparam int LEN_W    = 7;
    localparam int SUM_W    = ADDR_W + 1;

    localparam logic [BYTE_W-1:0] LITERAL_FLAG = 8'h80;
    localparam logic [BYTE_W-1:0] INDEX_MAX    = 8'hFF;

    typedef enum logic [1:0] {
        PH_LENGTH  = 2'd0,
        PH_HEADER  = 2'd1,
        PH_REPEAT  = 2'd2,
        PH_LITERAL = 2'd3
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] pixel_byte;
        logic [ADDR_W-1:0] start_address;
        logic [LEN_W-1:0]  run_length;
        logic              frame_end;
        logic              past_display;
    } run_t;

endpackage

`default_nettype wire

/* hw/rtl/rfd_in_reg.sv */
// Input register of the run-length frame decoder: holds one code word.
// Depends on rfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfd_in_reg
    import rfd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              code_valid,
    output logic                   code_stall,
    input  wire logic [BYTE_W-1:0] code_byte,
    input  wire logic              take,
    output logic                   held_valid,
    output logic [BYTE_W-1:0]      held_byte
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    assign code_stall = valid_reg && !take;
    assign valid_next = code_stall ? valid_reg : code_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!code_stall && code_valid)
        begin
            byte_reg <= code_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

`default_nettype wire

/* hw/rtl/rfd_core.sv */
// Decode state and run computation of the run-length frame decoder.
// Depends on rfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfd_core
    import rfd_pkg::*;
#(
    parameter int DISPLAY_BYTES = DISPLAY_BYTES_DEFAULT
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire logic [BYTE_W-1:0] code_byte,
    output logic                   emit,
    output run_t                   run
);

    localparam logic [SUM_W-1:0] DISPLAY_LIMIT = SUM_W'(DISPLAY_BYTES);

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [BYTE_W-1:0] frame_length_reg;
    logic [BYTE_W-1:0] frame_length_next;
    logic [BYTE_W-1:0] consumed_reg;
    logic [BYTE_W-1:0] consumed_next;
    logic [LEN_W-1:0]  literals_reg;
    logic [LEN_W-1:0]  literals_next;
    logic [LEN_W-1:0]  repeat_reg;
    logic [LEN_W-1:0]  repeat_next;
    logic [ADDR_W-1:0] cursor_reg;
    logic [ADDR_W-1:0] cursor_next;

    logic [BYTE_W-1:0] consumed_inc;
    logic              done_inc;
    logic [LEN_W-1:0]  literals_dec;
    logic [LEN_W-1:0]  run_len;
    logic [BYTE_W-1:0] run_pix;
    logic [ADDR_W-1:0] run_start;
    logic [SUM_W-1:0]  run_sum;
    logic              run_end;

    assign consumed_inc = (consumed_reg == INDEX_MAX) ? INDEX_MAX : consumed_reg + 8'd1;
    assign done_inc     = consumed_inc >= frame_length_reg;
    assign literals_dec = literals_reg - 7'd1;

    // Run descriptor for whatever this word produces.
    always_comb
    begin
        emit      = 1'b0;
        run_pix   = '0;
        run_len   = '0;
        run_start = cursor_reg;
        run_end   = 1'b0;
        unique case (phase_reg)
            PH_LENGTH:
            begin
                run_start = '0;
                run_end   = 1'b1;
                emit      = fire && (code_byte <= 8'd1);
            end
            PH_HEADER:
            begin
                run_end = 1'b1;
                emit    = fire && (code_byte == LITERAL_FLAG) && done_inc;
            end
            PH_REPEAT:
            begin
                run_pix = code_byte;
                run_len = repeat_reg;
                run_end = done_inc;
                emit    = fire;
            end
            PH_LITERAL:
            begin
                run_pix = code_byte;
                run_len = 7'd1;
                run_end = (literals_dec == '0) && done_inc;
                emit    = fire;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign run_sum = {1'b0, run_start} + SUM_W'(run_len);

    assign run.pixel_byte    = run_pix;
    assign run.start_address = run_start;
    assign run.run_length    = run_len;
    assign run.frame_end     = run_end;
    assign run.past_display  = run_sum > DISPLAY_LIMIT;

    always_comb
    begin
        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        consumed_next     = consumed_reg;
        literals_next     = literals_reg;
        repeat_next       = repeat_reg;
        cursor_next       = cursor_reg;
        if (fire)
        begin
            unique case (phase_reg)
                PH_LENGTH:
                begin
                    frame_length_next = code_byte;
                    consumed_next     = 8'd1;
                    literals_next     = '0;
                    repeat_next       = '0;
                    cursor_next       = '0;
                    phase_next        = (code_byte <= 8'd1) ? PH_LENGTH : PH_HEADER;
                end
                PH_HEADER:
                begin
                    consumed_next = consumed_inc;
                    if ((code_byte & LITERAL_FLAG) != '0)
                    begin
                        literals_next = code_byte[LEN_W-1:0];
                        if (code_byte[LEN_W-1:0] == '0)
                        begin
                            phase_next = done_inc ? PH_LENGTH : PH_HEADER;
                        end
                        else
                        begin
                            phase_next = PH_LITERAL;
                        end
                    end
                    else
                    begin
                        repeat_next = code_byte[LEN_W-1:0];
                        phase_next  = PH_REPEAT;
                    end
                end
                PH_REPEAT:
                begin
                    consumed_next = consumed_inc;
                    cursor_next   = run_sum[ADDR_W-1:0];
                    phase_next    = done_inc ? PH_LENGTH : PH_HEADER;
                end
                PH_LITERAL:
                begin
                    consumed_next = consumed_inc;
                    literals_next = literals_dec;
                    cursor_next   = run_sum[ADDR_W-1:0];
                    if (literals_dec == '0)
                    begin
                        phase_next = done_inc ? PH_LENGTH : PH_HEADER;
                    end
                end
                default:
                begin
                    phase_next = PH_LENGTH;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_LENGTH;
            frame_length_reg <= '0;
            consumed_reg     <= '0;
            literals_reg     <= '0;
            repeat_reg       <= '0;
            cursor_reg       <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            consumed_reg     <= consumed_next;
            literals_reg     <= literals_next;
            repeat_reg       <= repeat_next;
            cursor_reg       <= cursor_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rfd_out_reg.sv */
// Output register of the run-length frame decoder: holds one run word.
// Depends on rfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfd_out_reg
    import rfd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic load,
    input  run_t      run_in,
    output logic      room,
    output logic      run_valid,
    input  wire logic run_stall,
    output run_t      run_out
);

    logic valid_reg;
    logic valid_next;
    run_t run_reg;

    assign room = !valid_reg || !run_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (room)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (room && load)
        begin
            run_reg <= run_in;
        end
    end

    assign run_valid = valid_reg;
    assign run_out   = run_reg;

endmodule

`default_nettype wire

/* hw/rtl/rle_frame_run_decoder.sv */
// Top level of the run-length frame decoder: input register, decode core and
// output register. Depends on rfd_pkg, rfd_in_reg, rfd_core and rfd_out_reg.
//
// The code channel (code_valid, code_stall, code_byte) takes one word of the
// encoded frame stream per accepted cycle: a frame length, a run header or a
// data byte. The run channel (run_valid, run_stall and the run fields) gives
// one word per data byte, plus an empty run where a frame ends without one.
// Headers and length bytes of frames that do not end there give no word.
// A code word is accepted whenever code_valid is high and code_stall is low.
// It is held in the input register and is decoded into the output register as
// soon as that register has room. One code word is taken every cycle while the
// run side keeps up.
// When run_stall holds a waiting run word, decoding halts and the input
// register fills, after which code_stall rises; no word is lost.
// Reset clears both registers and returns the decoder to expecting a frame
// length with the display cursor at zero.
`timescale 1ns / 1ps
`default_nettype none

module rle_frame_run_decoder
    import rfd_pkg::*;
#(
    parameter int DISPLAY_BYTES = DISPLAY_BYTES_DEFAULT
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              code_valid,
    output logic                   code_stall,
    input  wire logic [BYTE_W-1:0] code_byte,
    output logic                   run_valid,
    input  wire logic              run_stall,
    output logic [BYTE_W-1:0]      pixel_byte,
    output logic [ADDR_W-1:0]      start_address,
    output logic [LEN_W-1:0]       run_length,
    output logic                   frame_end,
    output logic                   past_display
);

    logic              held_valid;
    logic [BYTE_W-1:0] held_byte;
    logic              room;
    logic              fire;
    logic              emit;
    run_t              run_new;
    run_t              run_out;

    assign fire = held_valid && room;

    rfd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code_byte  (code_byte),
        .take       (fire),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    rfd_core #(
        .DISPLAY_BYTES (DISPLAY_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .code_byte (held_byte),
        .emit      (emit),
        .run       (run_new)
    );

    rfd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit),
        .run_in    (run_new),
        .room      (room),
        .run_valid (run_valid),
        .run_stall (run_stall),
        .run_out   (run_out)
    );

    assign pixel_byte    = run_out.pixel_byte;
    assign start_address = run_out.start_address;
    assign run_length    = run_out.run_length;
    assign frame_end     = run_out.frame_end;
    assign past_display  = run_out.past_display;

endmodule

`default_nettype wire
